// ----- hdl/cir_pkg.sv -----
// Shared widths, codes, types and helpers for the collision impulse response block.
package cir_pkg;

  localparam int DW     = 32;              // velocity and position width
  localparam int DIFFW  = DW + 1;          // position or velocity difference
  localparam int MAGW   = DW;              // magnitude of a difference
  localparam int PRODW  = 2 * MAGW;        // one 32x32 product
  localparam int DOTW   = PRODW + 2;       // signed dot product
  localparam int DENW   = PRODW + 1;       // squared distance
  localparam int REST_W = 17;              // restitution register
  localparam int AW     = REST_W + 1;      // one plus restitution, Q2.16
  localparam int FACW   = AW + DENW;       // (1+e)*|dot|
  localparam int LOW    = 33;              // low split of |dot|
  localparam int HIW    = DENW - LOW;      // high split of |dot|
  localparam int CHW    = 28;              // chunk width of the factor
  localparam int PPW    = MAGW + CHW;      // partial product width
  localparam int NW     = MAGW + FACW;     // full numerator
  localparam int RSH    = REST_W;          // divide by 2^17 folded into a shift
  localparam int NPW    = NW - RSH;        // shifted numerator
  localparam int QB     = 35;              // quotient bits, |q| < 2^34
  localparam int RHW    = NPW - QB;        // numerator bits preloaded as remainder
  localparam int DELW   = QB + 1;          // signed velocity change
  localparam int SUMW   = DELW + 1;        // velocity plus change
  localparam int FRONT  = 8;               // stages ahead of the divider
  localparam int NSTG   = FRONT + QB + 1;  // all stages including the output

  localparam logic [REST_W-1:0] REST_RESET = 17'd58982;
  localparam logic [AW-1:0]     REST_ONE   = 18'd65536;

  typedef enum logic [1:0] {
    OUT_IMPULSE    = 2'd0,
    OUT_SEPARATING = 2'd1,
    OUT_COINCIDENT = 2'd2
  } cir_outcome_t;

  typedef struct packed {
    logic [DENW-1:0] rem_x;
    logic [DENW-1:0] rem_y;
    logic [QB-1:0]   lo_x;
    logic [QB-1:0]   lo_y;
    logic [QB-1:0]   q_x;
    logic [QB-1:0]   q_y;
    logic [DENW-1:0] den;
    logic            neg_x;
    logic            neg_y;
    cir_outcome_t    outcome;
    logic [DW-1:0]   v1x;
    logic [DW-1:0]   v1y;
    logic [DW-1:0]   v2x;
    logic [DW-1:0]   v2y;
  } cir_div_t;

  function automatic logic [DW-1:0] sat(input logic [SUMW-1:0] v);
    logic [DW-1:0] r;
    if (&v[SUMW-1:DW-1] || ~|v[SUMW-1:DW-1]) begin
      r = v[DW-1:0];
    end else if (v[SUMW-1]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- hdl/collision_impulse_response.sv -----
// Top level of the two-body equal-mass impulse collision response pipeline.
//
//   channel   direction  handshake              content
//   input     in         in_valid / in_stall    positions and velocities of both bodies
//   output    out        out_valid / out_stall  new velocities and outcome code
//   config    in/out     APB psel/penable       restitution at byte address 0
//
// One transaction enters per cycle while in_stall is low; the pipeline holds 8 arithmetic
// stages, 35 divider steps of one quotient bit each and one output stage. The 35-step
// quotient loop sets the depth; throughput is one transaction per cycle while out_stall is low.
// Synchronous reset clears all stage valid bits and loads restitution with 0.9.
// A stall on the output holds only the stages that are full up to the output;
// bubbles further back still close, so input is taken while a result waits.
module collision_impulse_response (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          first_pos_x,
  input  logic signed [31:0]          first_pos_y,
  input  logic signed [31:0]          first_vel_x,
  input  logic signed [31:0]          first_vel_y,
  input  logic signed [31:0]          second_pos_x,
  input  logic signed [31:0]          second_pos_y,
  input  logic signed [31:0]          second_vel_x,
  input  logic signed [31:0]          second_vel_y,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          new_first_vel_x,
  output logic signed [31:0]          new_first_vel_y,
  output logic signed [31:0]          new_second_vel_x,
  output logic signed [31:0]          new_second_vel_y,
  output logic [1:0]                  outcome,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int NS = cir_pkg::NSTG;

  // ---------------------------------------------------------------- config
  logic [cir_pkg::REST_W-1:0] restitution;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= cir_pkg::REST_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      restitution <= pwdata[cir_pkg::REST_W-1:0];
    end
  end

  // read back; only the first word is decoded
  assign prdata = paddr[2] ? 32'd0 : {{(32-cir_pkg::REST_W){1'b0}}, restitution};

  // ------------------------------------------------------- stage control
  // A stage may load when it is empty or everything after it moves.
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    logic [NS-1:0] lowmask;
    for (int s = 0; s < NS; s++) begin
      lowmask = (NS'(1) << s) - NS'(1);
      en[s]   = !out_stall || !(&(vld | lowmask));
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // ------------------------------------------------ stage 0: differences
  logic [cir_pkg::DIFFW-1:0] s0_dx, s0_dy, s0_rx, s0_ry;
  logic [cir_pkg::DW-1:0]    s0_v1x, s0_v1y, s0_v2x, s0_v2y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_dx  <= {first_pos_x[31], first_pos_x} - {second_pos_x[31], second_pos_x};
      s0_dy  <= {first_pos_y[31], first_pos_y} - {second_pos_y[31], second_pos_y};
      s0_rx  <= {first_vel_x[31], first_vel_x} - {second_vel_x[31], second_vel_x};
      s0_ry  <= {first_vel_y[31], first_vel_y} - {second_vel_y[31], second_vel_y};
      s0_v1x <= first_vel_x;
      s0_v1y <= first_vel_y;
      s0_v2x <= second_vel_x;
      s0_v2y <= second_vel_y;
    end
  end

  // ------------------------------------------- stage 1: four 32x32 products
  logic [cir_pkg::MAGW-1:0]  m_dx, m_dy, m_rx, m_ry;
  logic [cir_pkg::DIFFW-1:0] n_dx, n_dy, n_rx, n_ry;

  always_comb begin
    n_dx = cir_pkg::DIFFW'(0) - s0_dx;
    n_dy = cir_pkg::DIFFW'(0) - s0_dy;
    n_rx = cir_pkg::DIFFW'(0) - s0_rx;
    n_ry = cir_pkg::DIFFW'(0) - s0_ry;
    m_dx = s0_dx[cir_pkg::DIFFW-1] ? n_dx[cir_pkg::MAGW-1:0] : s0_dx[cir_pkg::MAGW-1:0];
    m_dy = s0_dy[cir_pkg::DIFFW-1] ? n_dy[cir_pkg::MAGW-1:0] : s0_dy[cir_pkg::MAGW-1:0];
    m_rx = s0_rx[cir_pkg::DIFFW-1] ? n_rx[cir_pkg::MAGW-1:0] : s0_rx[cir_pkg::MAGW-1:0];
    m_ry = s0_ry[cir_pkg::DIFFW-1] ? n_ry[cir_pkg::MAGW-1:0] : s0_ry[cir_pkg::MAGW-1:0];
  end

  logic [cir_pkg::PRODW-1:0] s1_pxr, s1_pyr, s1_pxx, s1_pyy;
  logic                      s1_nx, s1_ny, s1_sdx, s1_sdy;
  logic [cir_pkg::MAGW-1:0]  s1_mdx, s1_mdy;
  logic [cir_pkg::DW-1:0]    s1_v1x, s1_v1y, s1_v2x, s1_v2y;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_pxr <= cir_pkg::PRODW'(m_dx) * cir_pkg::PRODW'(m_rx);
      s1_pyr <= cir_pkg::PRODW'(m_dy) * cir_pkg::PRODW'(m_ry);
      s1_pxx <= cir_pkg::PRODW'(m_dx) * cir_pkg::PRODW'(m_dx);
      s1_pyy <= cir_pkg::PRODW'(m_dy) * cir_pkg::PRODW'(m_dy);
      s1_nx  <= s0_dx[cir_pkg::DIFFW-1] ^ s0_rx[cir_pkg::DIFFW-1];
      s1_ny  <= s0_dy[cir_pkg::DIFFW-1] ^ s0_ry[cir_pkg::DIFFW-1];
      s1_sdx <= s0_dx[cir_pkg::DIFFW-1];
      s1_sdy <= s0_dy[cir_pkg::DIFFW-1];
      s1_mdx <= m_dx;
      s1_mdy <= m_dy;
      s1_v1x <= s0_v1x;
      s1_v1y <= s0_v1y;
      s1_v2x <= s0_v2x;
      s1_v2y <= s0_v2y;
    end
  end

  // ----------------------------------- stage 2: dot product and |d|^2
  logic [cir_pkg::DOTW-1:0] sx, sy, ux, uy;

  always_comb begin
    ux = {2'b00, s1_pxr};
    uy = {2'b00, s1_pyr};
    sx = s1_nx ? cir_pkg::DOTW'(0) - ux : ux;
    sy = s1_ny ? cir_pkg::DOTW'(0) - uy : uy;
  end

  logic [cir_pkg::DOTW-1:0] s2_dot;
  logic [cir_pkg::DENW-1:0] s2_den;
  logic                     s2_sdx, s2_sdy;
  logic [cir_pkg::MAGW-1:0] s2_mdx, s2_mdy;
  logic [cir_pkg::DW-1:0]   s2_v1x, s2_v1y, s2_v2x, s2_v2y;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_dot <= sx + sy;
      s2_den <= {1'b0, s1_pxx} + {1'b0, s1_pyy};
      s2_sdx <= s1_sdx;
      s2_sdy <= s1_sdy;
      s2_mdx <= s1_mdx;
      s2_mdy <= s1_mdy;
      s2_v1x <= s1_v1x;
      s2_v1y <= s1_v1y;
      s2_v2x <= s1_v2x;
      s2_v2y <= s1_v2y;
    end
  end

  // ------------------------------ stage 3: classify, magnitude of the dot
  logic                     dneg;
  logic [cir_pkg::DOTW-1:0] ndot;
  cir_pkg::cir_outcome_t    oc;

  always_comb begin
    dneg = s2_dot[cir_pkg::DOTW-1];
    ndot = cir_pkg::DOTW'(0) - s2_dot;
    priority if (s2_den == '0) begin
      oc = cir_pkg::OUT_COINCIDENT;
    end else if (!dneg && (s2_dot != '0)) begin
      oc = cir_pkg::OUT_SEPARATING;
    end else begin
      oc = cir_pkg::OUT_IMPULSE;
    end
  end

  logic [cir_pkg::DENW-1:0] s3_mdot, s3_den;
  logic                     s3_negx, s3_negy;
  cir_pkg::cir_outcome_t    s3_oc;
  logic [cir_pkg::MAGW-1:0] s3_mdx, s3_mdy;
  logic [cir_pkg::DW-1:0]   s3_v1x, s3_v1y, s3_v2x, s3_v2y;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_mdot <= dneg ? ndot[cir_pkg::DENW-1:0] : s2_dot[cir_pkg::DENW-1:0];
      s3_den  <= s2_den;
      s3_negx <= dneg ^ s2_sdx;
      s3_negy <= dneg ^ s2_sdy;
      s3_oc   <= oc;
      s3_mdx  <= s2_mdx;
      s3_mdy  <= s2_mdy;
      s3_v1x  <= s2_v1x;
      s3_v1y  <= s2_v1y;
      s3_v2x  <= s2_v2x;
      s3_v2y  <= s2_v2y;
    end
  end

  // ------------------------- stage 4: (1+e) times |dot|, two partial products
  localparam int PLW = cir_pkg::AW + cir_pkg::LOW;
  localparam int PHW = cir_pkg::AW + cir_pkg::HIW;

  logic [cir_pkg::AW-1:0] rest_a;
  assign rest_a = cir_pkg::REST_ONE + {1'b0, restitution};

  logic [PLW-1:0]           s4_plo;
  logic [PHW-1:0]           s4_phi;
  logic [cir_pkg::DENW-1:0] s4_den;
  logic                     s4_negx, s4_negy;
  cir_pkg::cir_outcome_t    s4_oc;
  logic [cir_pkg::MAGW-1:0] s4_mdx, s4_mdy;
  logic [cir_pkg::DW-1:0]   s4_v1x, s4_v1y, s4_v2x, s4_v2y;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_plo  <= PLW'(rest_a) * PLW'(s3_mdot[cir_pkg::LOW-1:0]);
      s4_phi  <= PHW'(rest_a) * PHW'(s3_mdot[cir_pkg::DENW-1:cir_pkg::LOW]);
      s4_den  <= s3_den;
      s4_negx <= s3_negx;
      s4_negy <= s3_negy;
      s4_oc   <= s3_oc;
      s4_mdx  <= s3_mdx;
      s4_mdy  <= s3_mdy;
      s4_v1x  <= s3_v1x;
      s4_v1y  <= s3_v1y;
      s4_v2x  <= s3_v2x;
      s4_v2y  <= s3_v2y;
    end
  end

  // ------------------------------------------- stage 5: combine the factor
  logic [cir_pkg::FACW-1:0] s5_fac;
  logic [cir_pkg::DENW-1:0] s5_den;
  logic                     s5_negx, s5_negy;
  cir_pkg::cir_outcome_t    s5_oc;
  logic [cir_pkg::MAGW-1:0] s5_mdx, s5_mdy;
  logic [cir_pkg::DW-1:0]   s5_v1x, s5_v1y, s5_v2x, s5_v2y;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_fac  <= {s4_phi, {cir_pkg::LOW{1'b0}}} +
                 {{(cir_pkg::FACW-PLW){1'b0}}, s4_plo};
      s5_den  <= s4_den;
      s5_negx <= s4_negx;
      s5_negy <= s4_negy;
      s5_oc   <= s4_oc;
      s5_mdx  <= s4_mdx;
      s5_mdy  <= s4_mdy;
      s5_v1x  <= s4_v1x;
      s5_v1y  <= s4_v1y;
      s5_v2x  <= s4_v2x;
      s5_v2y  <= s4_v2y;
    end
  end

  // ----------------------- stage 6: |d_c| times factor, three chunks each
  localparam int C2W = cir_pkg::FACW - 2 * cir_pkg::CHW;

  logic [cir_pkg::CHW-1:0] fc0, fc1;
  logic [C2W-1:0]          fc2;

  assign fc0 = s5_fac[cir_pkg::CHW-1:0];
  assign fc1 = s5_fac[2*cir_pkg::CHW-1:cir_pkg::CHW];
  assign fc2 = s5_fac[cir_pkg::FACW-1:2*cir_pkg::CHW];

  logic [cir_pkg::PPW-1:0]  s6_px0, s6_px1, s6_px2, s6_py0, s6_py1, s6_py2;
  logic [cir_pkg::DENW-1:0] s6_den;
  logic                     s6_negx, s6_negy;
  cir_pkg::cir_outcome_t    s6_oc;
  logic [cir_pkg::DW-1:0]   s6_v1x, s6_v1y, s6_v2x, s6_v2y;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_px0  <= cir_pkg::PPW'(s5_mdx) * cir_pkg::PPW'(fc0);
      s6_px1  <= cir_pkg::PPW'(s5_mdx) * cir_pkg::PPW'(fc1);
      s6_px2  <= cir_pkg::PPW'(s5_mdx) * cir_pkg::PPW'(fc2);
      s6_py0  <= cir_pkg::PPW'(s5_mdy) * cir_pkg::PPW'(fc0);
      s6_py1  <= cir_pkg::PPW'(s5_mdy) * cir_pkg::PPW'(fc1);
      s6_py2  <= cir_pkg::PPW'(s5_mdy) * cir_pkg::PPW'(fc2);
      s6_den  <= s5_den;
      s6_negx <= s5_negx;
      s6_negy <= s5_negy;
      s6_oc   <= s5_oc;
      s6_v1x  <= s5_v1x;
      s6_v1y  <= s5_v1y;
      s6_v2x  <= s5_v2x;
      s6_v2y  <= s5_v2y;
    end
  end

  // ------------ stage 7: assemble numerators, fold in the divide by 2^17
  logic [cir_pkg::NW-1:0] num_x, num_y;

  always_comb begin
    num_x = cir_pkg::NW'(s6_px0) + (cir_pkg::NW'(s6_px1) << cir_pkg::CHW) +
            (cir_pkg::NW'(s6_px2) << (2 * cir_pkg::CHW));
    num_y = cir_pkg::NW'(s6_py0) + (cir_pkg::NW'(s6_py1) << cir_pkg::CHW) +
            (cir_pkg::NW'(s6_py2) << (2 * cir_pkg::CHW));
  end

  logic [cir_pkg::NPW-1:0]  s7_nx, s7_ny;
  logic [cir_pkg::DENW-1:0] s7_den;
  logic                     s7_negx, s7_negy;
  cir_pkg::cir_outcome_t    s7_oc;
  logic [cir_pkg::DW-1:0]   s7_v1x, s7_v1y, s7_v2x, s7_v2y;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_nx   <= num_x[cir_pkg::NW-1:cir_pkg::RSH];
      s7_ny   <= num_y[cir_pkg::NW-1:cir_pkg::RSH];
      s7_den  <= s6_den;
      s7_negx <= s6_negx;
      s7_negy <= s6_negy;
      s7_oc   <= s6_oc;
      s7_v1x  <= s6_v1x;
      s7_v1y  <= s6_v1y;
      s7_v2x  <= s6_v2x;
      s7_v2y  <= s6_v2y;
    end
  end

  // ------------------------------------- divider: one quotient bit a stage
  // The top bits of the numerator are below |d|^2, so they preload the remainder.
  cir_pkg::cir_div_t div_d [cir_pkg::QB+1];

  always_comb begin
    div_d[0].rem_x   = {{(cir_pkg::DENW-cir_pkg::RHW){1'b0}},
                        s7_nx[cir_pkg::NPW-1:cir_pkg::QB]};
    div_d[0].rem_y   = {{(cir_pkg::DENW-cir_pkg::RHW){1'b0}},
                        s7_ny[cir_pkg::NPW-1:cir_pkg::QB]};
    div_d[0].lo_x    = s7_nx[cir_pkg::QB-1:0];
    div_d[0].lo_y    = s7_ny[cir_pkg::QB-1:0];
    div_d[0].q_x     = '0;
    div_d[0].q_y     = '0;
    div_d[0].den     = s7_den;
    div_d[0].neg_x   = s7_negx;
    div_d[0].neg_y   = s7_negy;
    div_d[0].outcome = s7_oc;
    div_d[0].v1x     = s7_v1x;
    div_d[0].v1y     = s7_v1y;
    div_d[0].v2x     = s7_v2x;
    div_d[0].v2y     = s7_v2y;
  end

  for (genvar k = 0; k < cir_pkg::QB; k++) begin : g_div
    cir_div_stage u_step (
      .clk   (clk),
      .en    (en[cir_pkg::FRONT+k]),
      .d_in  (div_d[k]),
      .d_out (div_d[k+1])
    );
  end

  // ------------------------------ output stage: apply sign and saturate
  cir_pkg::cir_div_t       dq;
  logic [cir_pkg::DELW-1:0] qx, qy, dlx, dly;
  logic [cir_pkg::SUMW-1:0] sum1x, sum1y, sum2x, sum2y;

  always_comb begin
    dq  = div_d[cir_pkg::QB];
    qx  = {1'b0, dq.q_x};
    qy  = {1'b0, dq.q_y};
    // zero change unless the impulse applies
    dlx = '0;
    dly = '0;
    if (dq.outcome == cir_pkg::OUT_IMPULSE) begin
      dlx = dq.neg_x ? cir_pkg::DELW'(0) - qx : qx;
      dly = dq.neg_y ? cir_pkg::DELW'(0) - qy : qy;
    end
    sum1x = {{(cir_pkg::SUMW-cir_pkg::DW){dq.v1x[cir_pkg::DW-1]}}, dq.v1x} -
            {dlx[cir_pkg::DELW-1], dlx};
    sum1y = {{(cir_pkg::SUMW-cir_pkg::DW){dq.v1y[cir_pkg::DW-1]}}, dq.v1y} -
            {dly[cir_pkg::DELW-1], dly};
    sum2x = {{(cir_pkg::SUMW-cir_pkg::DW){dq.v2x[cir_pkg::DW-1]}}, dq.v2x} +
            {dlx[cir_pkg::DELW-1], dlx};
    sum2y = {{(cir_pkg::SUMW-cir_pkg::DW){dq.v2y[cir_pkg::DW-1]}}, dq.v2y} +
            {dly[cir_pkg::DELW-1], dly};
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      new_first_vel_x  <= cir_pkg::sat(sum1x);
      new_first_vel_y  <= cir_pkg::sat(sum1y);
      new_second_vel_x <= cir_pkg::sat(sum2x);
      new_second_vel_y <= cir_pkg::sat(sum2y);
      outcome          <= dq.outcome;
    end
  end

  assign out_valid = vld[NS-1];

endmodule

// ----- hdl/cir_div_stage.sv -----
// One registered restoring-division step for both velocity components.
module cir_div_stage (
  input  logic               clk,
  input  logic               en,
  input  cir_pkg::cir_div_t  d_in,
  output cir_pkg::cir_div_t  d_out
);

  logic [cir_pkg::DENW:0] sh_x, sh_y, den_e, sub_x, sub_y;
  logic                   ge_x, ge_y;
  cir_pkg::cir_div_t      d_next;

  always_comb begin
    den_e = {1'b0, d_in.den};
    sh_x  = {d_in.rem_x, d_in.lo_x[cir_pkg::QB-1]};
    sh_y  = {d_in.rem_y, d_in.lo_y[cir_pkg::QB-1]};
    ge_x  = sh_x >= den_e;
    ge_y  = sh_y >= den_e;
    sub_x = sh_x - den_e;
    sub_y = sh_y - den_e;
    d_next       = d_in;
    d_next.rem_x = ge_x ? sub_x[cir_pkg::DENW-1:0] : sh_x[cir_pkg::DENW-1:0];
    d_next.rem_y = ge_y ? sub_y[cir_pkg::DENW-1:0] : sh_y[cir_pkg::DENW-1:0];
    d_next.lo_x  = {d_in.lo_x[cir_pkg::QB-2:0], 1'b0};
    d_next.lo_y  = {d_in.lo_y[cir_pkg::QB-2:0], 1'b0};
    d_next.q_x   = {d_in.q_x[cir_pkg::QB-2:0], ge_x};
    d_next.q_y   = {d_in.q_y[cir_pkg::QB-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

// ----- hdl/cir_checker.sv -----
// Port-level checker for the collision impulse response block, with its bind.
module cir_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] new_first_vel_x,
  input logic [1:0]  outcome,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_first_vel_x) && $stable(outcome))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // reset loads restitution 0.9
  a_reset_rest: assert property (@(posedge clk)
    $past(rst) && !paddr[2] |-> prdata == 32'd58982)
    else $error("restitution reset value wrong");

  // a write to restitution reads back
  a_write_back: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && !paddr[2]
    |=> paddr[2] || (prdata == {15'd0, $past(pwdata[16:0])}))
    else $error("restitution write not seen on readback");

endmodule

bind collision_impulse_response cir_checker u_cir_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .new_first_vel_x (new_first_vel_x),
  .outcome         (outcome),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata)
);
